[hw/rtl/lmc_pkg.sv]
// Package for the light mode controller: transaction structs, mode, pattern,
// command and register codes, and default constants. No dependencies.
package lmc_pkg;

    localparam int MAX_MOVING_PATTERNS_DEF = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PATTERNS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_TMO    = 1'd1;

    localparam logic [4:0]  NUM_PATTERNS_RST = 5'd4;
    localparam logic [15:0] SELECT_TMO_RST   = 16'd10000;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_SET   = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;

    localparam logic [1:0] PWR_NORMAL   = 2'd0;
    localparam logic [1:0] PWR_CHARGING = 2'd1;
    localparam logic [1:0] PWR_CHARGED  = 2'd2;
    localparam logic [1:0] PWR_LOW      = 2'd3;

    localparam logic [1:0] MOT_MOVING  = 2'd0;
    localparam logic [1:0] MOT_STOPPED = 2'd1;
    localparam logic [1:0] MOT_PARKED  = 2'd2;

    localparam logic [1:0] BTN_SHORT  = 2'd1;
    localparam logic [1:0] BTN_TRIPLE = 2'd2;
    localparam logic [1:0] BTN_LONG   = 2'd3;

    localparam logic [3:0] M_PWR_ON   = 4'd0;
    localparam logic [3:0] M_GAUGE    = 4'd1;
    localparam logic [3:0] M_ON       = 4'd2;
    localparam logic [3:0] M_PWR_OFF  = 4'd3;
    localparam logic [3:0] M_OFF_WIFI = 4'd4;
    localparam logic [3:0] M_CHARGE   = 4'd5;
    localparam logic [3:0] M_OFF      = 4'd6;
    localparam logic [3:0] M_PARKED   = 4'd7;
    localparam logic [3:0] M_DAY      = 4'd8;
    localparam logic [3:0] M_SELECT   = 4'd9;
    localparam logic [3:0] M_WIFI     = 4'd10;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_BLANK = 2'd2;

    localparam logic [2:0] P_PWR_ON   = 3'd0;
    localparam logic [2:0] P_PWR_OFF  = 3'd1;
    localparam logic [2:0] P_CHARGING = 3'd2;
    localparam logic [2:0] P_DONE     = 3'd3;
    localparam logic [2:0] P_BATTERY  = 3'd4;
    localparam logic [2:0] P_STOPPED  = 3'd5;
    localparam logic [2:0] P_WIFI     = 3'd6;
    localparam logic [2:0] P_MOVING   = 3'd7;

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  pwr_source;
        logic [1:0]  motion;
        logic [1:0]  button_event;
        logic        button_held;
        logic        pattern_running;
        logic        usb_connected;
        logic        is_night;
        logic [9:0]  elapsed_ms;
        logic [3:0]  initial_state;
        logic [15:0] pattern_number;
    } t_in_item;

    typedef struct packed {
        logic [3:0] light_state;
        logic [1:0] pattern_cmd;
        logic [2:0] pattern_select;
        logic [3:0] moving_index;
        logic       multi_press_enable;
        logic       switch_enable;
    } t_out_item;

endpackage

[hw/rtl/light_mode_controller.sv]
// Light mode controller top level: input register, mode/timer/index update, result register.
// Depends on lmc_pkg.
// The input transaction is held in the input register, then the result in the result register;
// throughput: one transaction per cycle unless the output stalls, one pass through the logic.
// Reset (i_rst_n low, synchronous): pipeline empty, mode off, moving index 1, timer 0,
// multi-press and supply switch off, registers at 4 patterns and 10000 ms timeout.
module light_mode_controller
    import lmc_pkg::*;
#(
    parameter int MAX_MOVING_PATTERNS = MAX_MOVING_PATTERNS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    // count is a 5-bit register, so the limit never exceeds 31
    localparam int LIM   = (MAX_MOVING_PATTERNS < 31) ? MAX_MOVING_PATTERNS : 31;
    localparam int IDX_W = $clog2(LIM);

    logic [4:0]       r_num;
    logic [15:0]      r_tmo;
    logic             r_in_valid;
    t_in_item         r_in;
    logic             r_out_valid;
    t_out_item        r_out;
    logic [3:0]       r_mode;
    logic [IDX_W-1:0] r_idx;
    logic [15:0]      r_sel;
    logic             r_mpf;
    logic             r_sup;

    logic [3:0]       n_mode;
    logic [IDX_W-1:0] n_idx;
    logic [15:0]      n_sel;
    logic             n_mpf;
    logic             n_sup;
    t_out_item        n_out;

    logic             w_adv;
    logic             go;
    logic [3:0]       go_tgt;
    logic [1:0]       cmd;
    logic [2:0]       pat;
    logic [16:0]      sum;
    logic [4:0]       cnt;
    logic [IDX_W:0]   idx_inc;
    logic             on_ext;
    logic [IDX_W+3:0] idx_ext;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= NUM_PATTERNS_RST;
            r_tmo <= SELECT_TMO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUM_PATTERNS: r_num <= i_cfg_data[4:0];
                CFG_SELECT_TMO:   r_tmo <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_idx   = r_idx;
        n_sel   = r_sel;
        n_mpf   = r_mpf;
        n_sup   = r_sup;
        go      = 1'b0;
        go_tgt  = r_mode;
        cmd     = CMD_NONE;
        pat     = P_PWR_ON;
        sum     = {1'b0, r_sel} + 17'(r_in.elapsed_ms);
        cnt     = ({1'b0, r_num} > 6'(LIM)) ? 5'(LIM) : r_num;
        idx_inc = {1'b0, r_idx} + (IDX_W+1)'(1);
        on_ext  = (r_in.pwr_source == PWR_CHARGING) || (r_in.pwr_source == PWR_CHARGED);

        unique case (r_in.func)
            FUNC_TICK: begin
                n_sel = sum[16] ? 16'hFFFF : sum[15:0];
                unique case (r_mode)
                    M_PWR_ON: begin
                        if (!r_in.pattern_running) begin go = 1'b1; go_tgt = M_GAUGE; end
                    end
                    M_GAUGE: begin
                        go = 1'b1;
                        priority if (on_ext) go_tgt = M_CHARGE;
                        else if (!r_in.pattern_running)
                            go_tgt = (r_in.pwr_source == PWR_LOW) ? M_OFF : M_ON;
                        else if (r_in.button_event == BTN_TRIPLE) go_tgt = M_WIFI;
                        else if (r_in.button_event == BTN_SHORT) go_tgt = M_SELECT;
                        else go = 1'b0;
                    end
                    M_ON: begin
                        go = 1'b1;
                        priority if (on_ext) go_tgt = M_CHARGE;
                        else if (r_in.pwr_source == PWR_LOW || r_in.button_event == BTN_SHORT)
                            go_tgt = M_GAUGE;
                        else if (r_in.button_event == BTN_LONG) go_tgt = M_PWR_OFF;
                        else if (r_in.motion == MOT_MOVING) begin
                            go = 1'b0; cmd = CMD_SET; pat = P_MOVING;
                        end else if (r_in.motion == MOT_STOPPED) begin
                            go = 1'b0; cmd = CMD_SET; pat = P_STOPPED;
                        end else if (r_in.motion == MOT_PARKED) go_tgt = M_PARKED;
                        else go = 1'b0;
                    end
                    M_PWR_OFF: begin
                        go = 1'b1;
                        priority if (!r_in.pattern_running) go_tgt = M_OFF;
                        else if (!r_in.button_held) go_tgt = M_ON;
                        else go = 1'b0;
                    end
                    M_OFF_WIFI: begin
                        go = 1'b1;
                        priority if (!r_in.pattern_running) go_tgt = M_OFF;
                        else if (!r_in.button_held) go_tgt = M_WIFI;
                        else go = 1'b0;
                    end
                    M_CHARGE: begin
                        priority if (r_in.pwr_source == PWR_CHARGED) begin
                            cmd = CMD_SET; pat = P_DONE;
                        end else if (r_in.pwr_source == PWR_CHARGING) begin
                            cmd = CMD_SET; pat = P_CHARGING;
                        end else begin
                            go = 1'b1; go_tgt = M_OFF;
                        end
                    end
                    M_SELECT: begin
                        cmd = CMD_SET;
                        pat = P_MOVING;
                        priority if (n_sel >= r_tmo) begin
                            go = 1'b1; go_tgt = M_ON;
                        end else if (r_in.button_event == BTN_SHORT) begin
                            n_idx = (6'(idx_inc) >= 6'(cnt)) ? '0 : idx_inc[IDX_W-1:0];
                        end
                    end
                    M_WIFI: begin
                        go = 1'b1;
                        priority if (r_in.pwr_source == PWR_LOW) go_tgt = M_GAUGE;
                        else if (r_in.button_event == BTN_LONG) go_tgt = M_OFF_WIFI;
                        else go = 1'b0;
                    end
                    default: ;
                endcase
            end
            FUNC_SET: begin
                n_idx = (r_in.pattern_number >= 16'(cnt)) ? '0 : r_in.pattern_number[IDX_W-1:0];
            end
            FUNC_START: begin
                priority if (r_in.initial_state == M_PARKED && !r_in.button_held
                             && !r_in.usb_connected && !r_in.is_night) begin
                    n_mode = M_DAY;
                end else if (r_in.initial_state == M_DAY && !r_in.button_held
                             && !r_in.usb_connected) begin
                    n_mode = M_PARKED;
                end else begin
                    n_sup  = 1'b1;
                    n_mode = r_in.initial_state;
                    go     = 1'b1;
                    go_tgt = M_PWR_ON;
                end
            end
            default: ;
        endcase

        // mode entry actions; re-entering the current mode does nothing
        if (go && go_tgt != n_mode) begin
            unique case (go_tgt)
                M_PWR_ON:              begin cmd = CMD_SET; pat = P_PWR_ON;  end
                M_GAUGE:               begin cmd = CMD_SET; pat = P_BATTERY; end
                M_PWR_OFF, M_OFF_WIFI: begin cmd = CMD_SET; pat = P_PWR_OFF; end
                M_OFF, M_PARKED:       begin cmd = CMD_BLANK; pat = P_PWR_ON; end
                M_SELECT:              n_sel = '0;
                M_WIFI:                begin cmd = CMD_SET; pat = P_WIFI;    end
                default: ;
            endcase
            n_mpf  = (go_tgt == M_GAUGE);
            n_mode = go_tgt;
        end

        idx_ext                  = {4'd0, n_idx};
        n_out.light_state        = n_mode;
        n_out.pattern_cmd        = cmd;
        n_out.pattern_select     = (cmd == CMD_SET) ? pat : P_PWR_ON;
        n_out.moving_index       = idx_ext[3:0];
        n_out.multi_press_enable = n_mpf;
        n_out.switch_enable      = n_sup;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= M_OFF;
            r_idx       <= IDX_W'(1);
            r_sel       <= '0;
            r_mpf       <= 1'b0;
            r_sup       <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_idx       <= n_idx;
                r_sel       <= n_sel;
                r_mpf       <= n_mpf;
                r_sup       <= n_sup;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hw/rtl/lmc_checker.sv]
// Port-level checker for the light mode controller, bound to the top level.
// Depends on lmc_pkg.
module lmc_checker
    import lmc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.light_state <= M_WIFI)
        else $error("light_state out of range");

    a_select_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pattern_cmd != CMD_SET |-> o_out_data.pattern_select == P_PWR_ON)
        else $error("pattern_select set without set command");

    a_blank_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pattern_cmd == CMD_BLANK
            |-> o_out_data.light_state == M_OFF || o_out_data.light_state == M_PARKED)
        else $error("blank command outside off or parked");

endmodule

bind light_mode_controller lmc_checker u_lmc_checker (.*);

[bench/light_mode_controller_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for light_mode_controller: queue-fed driver, clocked monitor and
// an in-bench mode predictor. Depends on lmc_pkg and the light_mode_controller RTL.
module light_mode_controller_test;
    import lmc_pkg::*;

    localparam int IDLE_PCT = 13;
    localparam int LATENCY = 2;
    localparam int TIMER_MAX = 65535;
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam logic [1:0] BTN_NONE = 2'd0;
    localparam logic [1:0] MOT_UNDEF = 2'd3;
    localparam logic [3:0] M_BEYOND = 4'd15;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_item o_out_data;

    light_mode_controller dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted controller state
    logic [3:0] lm_mode = M_OFF;
    int lm_index = 1;
    int lm_timer = 0;
    logic lm_gauge = 1'b0;
    logic lm_supply = 1'b0;
    logic [4:0] cfg_npat = NUM_PATTERNS_RST;
    logic [15:0] cfg_tmo = SELECT_TMO_RST;
    logic [1:0] cmd_kind;
    logic [2:0] cmd_pat;

    t_in_item pending_items[$];
    t_out_item expected_lights[$];
    int n_issued = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_faults = 0;
    int n_made = 0;
    bit quiet = 1'b0;

    function automatic int patterns_in_use();
        return (cfg_npat > MAX_MOVING_PATTERNS_DEF) ? MAX_MOVING_PATTERNS_DEF : int'(cfg_npat);
    endfunction

    task automatic issue_cmd(input logic [1:0] kind, input logic [2:0] pat);
        cmd_kind = kind;
        cmd_pat = (kind == CMD_SET) ? pat : '0;
    endtask

    task automatic enter_mode(input logic [3:0] target);
        if (target != lm_mode) begin
            case (target)
                M_PWR_ON: issue_cmd(CMD_SET, P_PWR_ON);
                M_GAUGE: issue_cmd(CMD_SET, P_BATTERY);
                M_PWR_OFF, M_OFF_WIFI: issue_cmd(CMD_SET, P_PWR_OFF);
                M_OFF, M_PARKED: issue_cmd(CMD_BLANK, '0);
                M_SELECT: lm_timer = 0;
                M_WIFI: issue_cmd(CMD_SET, P_WIFI);
                default: ;
            endcase
            lm_gauge = (target == M_GAUGE);
            lm_mode = target;
        end
    endtask

    task automatic predict_light(input t_in_item it, output t_out_item res);
        int sum;
        logic ext;
        logic [1:0] pwr;
        logic [1:0] btn;
        pwr = it.pwr_source;
        btn = it.button_event;
        ext = (pwr == PWR_CHARGING) || (pwr == PWR_CHARGED);
        cmd_kind = CMD_NONE;
        cmd_pat = '0;
        case (it.func)
            FUNC_TICK: begin
                sum = lm_timer + int'(it.elapsed_ms);
                lm_timer = (sum > TIMER_MAX) ? TIMER_MAX : sum;
                case (lm_mode)
                    M_PWR_ON: if (!it.pattern_running) enter_mode(M_GAUGE);
                    M_GAUGE: begin
                        if (ext) enter_mode(M_CHARGE);
                        else if (!it.pattern_running) enter_mode(pwr == PWR_LOW ? M_OFF : M_ON);
                        else if (btn == BTN_TRIPLE) enter_mode(M_WIFI);
                        else if (btn == BTN_SHORT) enter_mode(M_SELECT);
                    end
                    M_ON: begin
                        if (ext) enter_mode(M_CHARGE);
                        else if (pwr == PWR_LOW || btn == BTN_SHORT) enter_mode(M_GAUGE);
                        else if (btn == BTN_LONG) enter_mode(M_PWR_OFF);
                        else if (it.motion == MOT_MOVING) issue_cmd(CMD_SET, P_MOVING);
                        else if (it.motion == MOT_STOPPED) issue_cmd(CMD_SET, P_STOPPED);
                        else if (it.motion == MOT_PARKED) enter_mode(M_PARKED);
                    end
                    M_PWR_OFF: begin
                        if (!it.pattern_running) enter_mode(M_OFF);
                        else if (!it.button_held) enter_mode(M_ON);
                    end
                    M_OFF_WIFI: begin
                        if (!it.pattern_running) enter_mode(M_OFF);
                        else if (!it.button_held) enter_mode(M_WIFI);
                    end
                    M_CHARGE: begin
                        if (pwr == PWR_CHARGED) issue_cmd(CMD_SET, P_DONE);
                        else if (pwr == PWR_CHARGING) issue_cmd(CMD_SET, P_CHARGING);
                        else enter_mode(M_OFF);
                    end
                    M_SELECT: begin
                        // commanded pattern is reported with the index after any advance
                        issue_cmd(CMD_SET, P_MOVING);
                        if (lm_timer >= int'(cfg_tmo)) begin
                            enter_mode(M_ON);
                        end else if (btn == BTN_SHORT) begin
                            lm_index++;
                            if (lm_index >= patterns_in_use()) lm_index = 0;
                        end
                    end
                    M_WIFI: begin
                        if (pwr == PWR_LOW) enter_mode(M_GAUGE);
                        else if (btn == BTN_LONG) enter_mode(M_OFF_WIFI);
                    end
                    default: ;
                endcase
            end
            FUNC_SET: begin
                lm_index = (int'(it.pattern_number) >= patterns_in_use()) ?
                    0 : int'(it.pattern_number);
            end
            FUNC_START: begin
                if (it.initial_state == M_PARKED && !it.button_held && !it.usb_connected &&
                        !it.is_night) begin
                    lm_mode = M_DAY;
                end else if (it.initial_state == M_DAY && !it.button_held &&
                        !it.usb_connected) begin
                    lm_mode = M_PARKED;
                end else begin
                    lm_supply = 1'b1;
                    lm_mode = it.initial_state;
                    enter_mode(M_PWR_ON);
                end
            end
            default: ;
        endcase
        res.light_state = lm_mode;
        res.pattern_cmd = cmd_kind;
        res.pattern_select = cmd_pat;
        res.moving_index = lm_index[3:0];
        res.multi_press_enable = lm_gauge;
        res.switch_enable = lm_supply;
    endtask

    task automatic note_fault(input string msg);
        n_faults++;
        if (n_faults <= 10) $display("%s", msg);
    endtask

    // monitor: checks results, records accepted transactions
    always @(posedge i_clk) begin : scoreboard
        t_out_item want;
        t_out_item pred;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (expected_lights.size() == 0) begin
                    note_fault($sformatf("result %0d unexpected: %p", n_results, o_out_data));
                end else begin
                    want = expected_lights.pop_front();
                    if (o_out_data.light_state !== want.light_state ||
                            o_out_data.pattern_cmd !== want.pattern_cmd ||
                            o_out_data.pattern_select !== want.pattern_select ||
                            o_out_data.moving_index !== want.moving_index ||
                            o_out_data.multi_press_enable !== want.multi_press_enable ||
                            o_out_data.switch_enable !== want.switch_enable)
                        note_fault($sformatf("result %0d mismatch: expected %p, actual %p",
                            n_results, want, o_out_data));
                end
            end
            if (i_in_valid && o_in_ready) begin
                predict_light(i_in_data, pred);
                expected_lights.push_back(pred);
                n_accepted++;
            end
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (n_accepted == n_issued) begin
            if (pending_items.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                i_in_data <= pending_items.pop_front();
                i_in_valid <= 1'b1;
                n_issued++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic logic [1:0] rnd2();
        return 2'($urandom_range(0, 3));
    endfunction

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [1:0] norm_pwr();
        return ($urandom_range(0, 6) == 0) ? rnd2() : PWR_NORMAL;
    endfunction

    function automatic logic [9:0] gap_ms();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return 10'($urandom_range(0, 1023));
        if (pick == 1) return 10'd1000;
        return 10'($urandom_range(0, 150));
    endfunction

    function automatic t_in_item noise_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return t_in_item'(raw[$bits(t_in_item)-1:0]);
    endfunction

    function automatic t_in_item mk_tick(input logic [1:0] pwr, input logic [1:0] mot,
            input logic [1:0] btn, input logic held, input logic run);
        t_in_item it;
        it = noise_item();
        it.func = FUNC_TICK;
        it.pwr_source = pwr;
        it.motion = mot;
        it.button_event = btn;
        it.button_held = held;
        it.pattern_running = run;
        it.elapsed_ms = gap_ms();
        return it;
    endfunction

    function automatic t_in_item mk_start(input logic [3:0] req, input logic held,
            input logic usb, input logic night);
        t_in_item it;
        it = noise_item();
        it.func = FUNC_START;
        it.initial_state = req;
        it.button_held = held;
        it.usb_connected = usb;
        it.is_night = night;
        return it;
    endfunction

    function automatic t_in_item mk_set();
        t_in_item it;
        it = noise_item();
        it.func = FUNC_SET;
        if ($urandom_range(0, 3) != 0) it.pattern_number = 16'($urandom_range(0, 20));
        return it;
    endfunction

    task automatic add_item(input t_in_item it);
        pending_items.push_back(it);
        n_made++;
    endtask

    // power-up, then one ride through the gauge into a random branch; or a parked or day start, then random ticks
    task automatic queue_episode();
        t_in_item it;
        logic [3:0] req;
        logic usb;
        int n;
        bit deep;
        if ($urandom_range(0, 4) == 0) begin
            add_item(mk_start(coin() ? M_PARKED : M_DAY, 1'b0, 1'b0, coin()));
            repeat ($urandom_range(1, 3)) add_item(mk_tick(rnd2(), rnd2(), rnd2(), coin(), coin()));
            return;
        end
        req = 4'($urandom_range(0, 15));
        usb = coin();
        if (req == M_PARKED || req == M_DAY) usb = 1'b1;
        add_item(mk_start(req, coin(), usb, coin()));
        repeat ($urandom_range(0, 2)) add_item(mk_tick(rnd2(), rnd2(), rnd2(), coin(), 1'b1));
        add_item(mk_tick(norm_pwr(), rnd2(), rnd2(), coin(), 1'b0));
        case ($urandom_range(0, 5))
            0: begin
                add_item(mk_tick(PWR_NORMAL, rnd2(), rnd2(), coin(), 1'b0));
                repeat ($urandom_range(3, 12))
                    add_item(mk_tick(norm_pwr(), rnd2(),
                        ($urandom_range(0, 5) == 0) ? rnd2() : BTN_NONE, coin(), coin()));
                add_item(mk_tick(PWR_NORMAL, rnd2(), BTN_LONG, 1'b1, 1'b1));
                repeat ($urandom_range(0, 3))
                    add_item(mk_tick(PWR_NORMAL, rnd2(), rnd2(), 1'b1, 1'b1));
                add_item(mk_tick(rnd2(), rnd2(), rnd2(), coin(), coin()));
            end
            1: begin
                add_item(mk_tick(PWR_NORMAL, rnd2(), BTN_TRIPLE, coin(), 1'b1));
                repeat ($urandom_range(1, 5))
                    add_item(mk_tick(norm_pwr(), rnd2(),
                        ($urandom_range(0, 3) == 0) ? rnd2() : BTN_NONE, coin(), coin()));
                if (coin()) begin
                    add_item(mk_tick(PWR_LOW, rnd2(), rnd2(), coin(), coin()));
                end else begin
                    add_item(mk_tick(PWR_NORMAL, rnd2(), BTN_LONG, 1'b1, 1'b1));
                    repeat ($urandom_range(0, 3))
                        add_item(mk_tick(PWR_NORMAL, rnd2(), rnd2(), 1'b1, 1'b1));
                    add_item(mk_tick(rnd2(), rnd2(), rnd2(), coin(), coin()));
                end
            end
            2: begin
                add_item(mk_tick(PWR_NORMAL, rnd2(), BTN_SHORT, coin(), 1'b1));
                deep = ($urandom_range(0, 9) == 0);
                n = deep ? $urandom_range(70, 140) : $urandom_range(3, 30);
                repeat (n) begin
                    if ($urandom_range(0, 15) == 0) begin
                        add_item(mk_set());
                    end else begin
                        it = mk_tick(rnd2(), rnd2(), coin() ? BTN_SHORT : rnd2(), coin(), coin());
                        if (deep) it.elapsed_ms = 10'($urandom_range(900, 1023));
                        add_item(it);
                    end
                end
            end
            3: begin
                add_item(mk_tick(2'($urandom_range(1, 2)), rnd2(), rnd2(), coin(), coin()));
                repeat ($urandom_range(1, 5))
                    add_item(mk_tick(2'($urandom_range(1, 2)), rnd2(), rnd2(), coin(), coin()));
                add_item(mk_tick(coin() ? PWR_NORMAL : PWR_LOW, rnd2(), rnd2(), coin(), coin()));
            end
            4: add_item(mk_tick(PWR_LOW, rnd2(), rnd2(), coin(), 1'b0));
            default: begin
                repeat ($urandom_range(1, 4))
                    add_item(mk_tick(norm_pwr(), rnd2(), coin() ? BTN_LONG : BTN_NONE,
                        coin(), 1'b1));
                add_item(mk_tick(rnd2(), rnd2(), rnd2(), coin(), coin()));
            end
        endcase
    endtask

    task automatic queue_random(input int count);
        int target;
        int pick;
        target = n_made + count;
        while (n_made < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) add_item(noise_item());
            else if (pick < 12) add_item(mk_set());
            else queue_episode();
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || n_accepted != n_issued ||
                expected_lights.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        if (idx == CFG_NUM_PATTERNS) cfg_npat = data[4:0];
        else cfg_tmo = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        #2_000_000;
        $display("light_mode_controller regression: fail");
        $finish;
    end

    initial begin
        t_in_item it;
        int np;
        int tm;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset state, then reset index kept under a one-pattern count
        add_item(mk_tick(PWR_NORMAL, MOT_MOVING, BTN_NONE, 1'b0, 1'b1));
        wait_idle();
        program_reg(CFG_NUM_PATTERNS, 16'd1);
        it = noise_item();
        it.func = FUNC_NONE;
        add_item(it);
        wait_idle();
        program_reg(CFG_NUM_PATTERNS, 16'(NUM_PATTERNS_RST));

        it = mk_tick(PWR_NORMAL, MOT_MOVING, BTN_NONE, 1'b0, 1'b0);
        it.elapsed_ms = 10'd1000;
        add_item(it);
        it = '1;
        it.func = FUNC_NONE;
        add_item(it);
        it = mk_set();
        it.pattern_number = 16'd3;
        add_item(it);
        it.pattern_number = 16'hFFFF;
        add_item(it);
        add_item(mk_start(M_PARKED, 1'b0, 1'b0, 1'b0));
        add_item(mk_start(M_DAY, 1'b0, 1'b0, 1'b1));
        add_item(mk_start(M_DAY, 1'b0, 1'b1, 1'b0));
        add_item(mk_tick(PWR_NORMAL, MOT_MOVING, BTN_NONE, 1'b0, 1'b1));
        add_item(mk_tick(PWR_LOW, MOT_MOVING, BTN_NONE, 1'b0, 1'b0));
        it = mk_tick(PWR_NORMAL, MOT_MOVING, BTN_SHORT, 1'b0, 1'b1);
        it.elapsed_ms = 10'd0;
        add_item(it);
        it.elapsed_ms = 10'd10;
        add_item(it);
        it.elapsed_ms = 10'h3FF;
        add_item(it);
        add_item(mk_start(M_PWR_ON, 1'b1, 1'b1, 1'b1));
        add_item(mk_tick(PWR_NORMAL, MOT_MOVING, BTN_NONE, 1'b0, 1'b0));
        add_item(mk_tick(PWR_CHARGING, MOT_MOVING, BTN_NONE, 1'b0, 1'b1));
        add_item(mk_tick(PWR_CHARGED, MOT_STOPPED, BTN_NONE, 1'b0, 1'b1));
        add_item(mk_tick(PWR_CHARGING, MOT_PARKED, BTN_NONE, 1'b0, 1'b1));
        add_item(mk_tick(PWR_NORMAL, MOT_MOVING, BTN_NONE, 1'b0, 1'b1));
        add_item(mk_start(M_BEYOND, 1'b0, 1'b0, 1'b1));
        add_item(mk_tick(PWR_NORMAL, MOT_MOVING, BTN_NONE, 1'b0, 1'b0));
        add_item(mk_tick(PWR_NORMAL, MOT_MOVING, BTN_TRIPLE, 1'b0, 1'b1));
        add_item(mk_tick(PWR_NORMAL, MOT_MOVING, BTN_LONG, 1'b1, 1'b1));
        add_item(mk_tick(PWR_NORMAL, MOT_MOVING, BTN_NONE, 1'b0, 1'b1));
        add_item(mk_tick(PWR_LOW, MOT_MOVING, BTN_NONE, 1'b0, 1'b1));
        add_item(mk_tick(PWR_NORMAL, MOT_MOVING, BTN_NONE, 1'b0, 1'b0));
        add_item(mk_tick(PWR_NORMAL, MOT_UNDEF, BTN_NONE, 1'b0, 1'b1));
        add_item(mk_tick(PWR_NORMAL, MOT_PARKED, BTN_NONE, 1'b0, 1'b1));
        wait_idle();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin np = 16; tm = 0; end
                1: begin np = 1; tm = TIMER_MAX; end
                2: begin np = 0; tm = 300; end
                3: begin np = 31; tm = 2000; end
                default: begin
                    np = $urandom_range(2, 15);
                    tm = $urandom_range(50, 3000);
                end
            endcase
            program_reg(CFG_NUM_PATTERNS, 16'(np));
            program_reg(CFG_SELECT_TMO, 16'(tm));
            quiet = (ph == 2);
            queue_random(170);
            wait_idle();
        end
        quiet = 1'b0;

        if (n_faults == 0)
            $display("light_mode_controller regression: pass");
        else
            $display("light_mode_controller regression: fail");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/lmc_pkg.sv
hw/rtl/light_mode_controller.sv
hw/rtl/lmc_checker.sv
bench/light_mode_controller_test.sv
